// ===== rtl/core/scfr_pkg.sv =====
`default_nettype none

package scfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // frame layout
    localparam logic [INDEX_W-1:0] ADDR_INDEX = INDEX_W'(4);
    localparam logic [INDEX_W:0]   HEAD_BYTES = (INDEX_W + 1)'(3);

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd2;

    localparam logic [BYTE_W-1:0] RST_FIRST_HEADER  = 8'h55;
    localparam logic [BYTE_W-1:0] RST_SECOND_HEADER = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_LOCAL_ADDRESS = 8'h01;

    typedef struct packed {
        logic [BYTE_W-1:0] first_header;
        logic [BYTE_W-1:0] second_header;
        logic [BYTE_W-1:0] local_address;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/core/scfr_regs.sv =====
`default_nettype none

module scfr_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [scfr_pkg::APB_AW-1:0] paddr,
    input  wire logic [scfr_pkg::APB_DW-1:0] pwdata,
    output logic      [scfr_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output scfr_pkg::t_cfg                  o_cfg
);
    import scfr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= RST_FIRST_HEADER;
            r_cfg.second_header <= RST_SECOND_HEADER;
            r_cfg.local_address <= RST_LOCAL_ADDRESS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FIRST_HEADER:  r_cfg.first_header  <= pwdata[BYTE_W-1:0];
                REG_SECOND_HEADER: r_cfg.second_header <= pwdata[BYTE_W-1:0];
                REG_LOCAL_ADDRESS: r_cfg.local_address <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // misaligned reads return zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (reg_idx)
                REG_FIRST_HEADER:  prdata = APB_DW'(r_cfg.first_header);
                REG_SECOND_HEADER: prdata = APB_DW'(r_cfg.second_header);
                REG_LOCAL_ADDRESS: prdata = APB_DW'(r_cfg.local_address);
                default:           prdata = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/serial_command_frame_receiver.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_rx_byte
// out      | output    | o_out_valid / i_out_ready | o_frame_byte, o_byte_index, o_last_byte,
//          |           |                           | o_checksum_ok, o_address_ok
// config   | input     | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One beat per cycle while the output is not stalled: each byte is decoded against
// the frame state registers, and a byte kept as part of a frame lands in the
// output register at the edge it is accepted.
// The output register is the only buffer; the input is taken whenever it is
// empty or being drained in the same cycle, so o_in_ready follows i_out_ready.
// Synchronous active-low reset returns to hunting for the first header.
`default_nettype none

module serial_command_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [scfr_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [scfr_pkg::BYTE_W-1:0]  o_frame_byte,
    output logic      [scfr_pkg::INDEX_W-1:0] o_byte_index,
    output logic                             o_last_byte,
    output logic                             o_checksum_ok,
    output logic                             o_address_ok,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scfr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [scfr_pkg::APB_DW-1:0]  pwdata,
    output logic      [scfr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import scfr_pkg::*;

    t_cfg cfg;

    scfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame state
    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [INDEX_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]   r_sum, n_sum;
    logic                r_seen, n_seen;

    // output register
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic [INDEX_W-1:0]  r_index;
    logic                r_last, r_sum_ok, r_addr_ok;

    logic                in_fire;
    logic                emit, emit_last, emit_sum_ok, emit_addr_ok;
    logic                seen_now, is_last;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign seen_now = r_seen || ((r_count == ADDR_INDEX) && (i_rx_byte == cfg.local_address));
    assign is_last  = ((INDEX_W + 1)'(r_count) + (INDEX_W + 1)'(1))
                      >= ((INDEX_W + 1)'(r_len) + HEAD_BYTES);

    always_comb begin
        n_phase      = r_phase;
        n_len        = r_len;
        n_count      = r_count + INDEX_W'(1);
        n_sum        = r_sum + i_rx_byte;
        n_seen       = r_seen;
        emit         = 1'b1;
        emit_last    = 1'b0;
        emit_sum_ok  = 1'b0;
        emit_addr_ok = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                n_count = INDEX_W'(1);
                n_sum   = i_rx_byte;
                n_seen  = 1'b0;
                n_len   = '0;
                if (i_rx_byte == cfg.first_header) begin
                    n_phase = PH_SECOND;
                end else begin
                    emit    = 1'b0;
                    n_count = '0;
                    n_sum   = '0;
                end
            end
            PH_SECOND: begin
                if (i_rx_byte == cfg.second_header) begin
                    n_phase = PH_LENGTH;
                end else begin
                    emit    = 1'b0;
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_sum   = '0;
                    n_len   = '0;
                    n_seen  = 1'b0;
                end
            end
            PH_LENGTH: begin
                n_len   = i_rx_byte;
                n_phase = PH_BODY;
            end
            PH_BODY: begin
                n_seen = seen_now;
                if (is_last) begin
                    emit_last    = 1'b1;
                    emit_sum_ok  = (r_sum == i_rx_byte);
                    emit_addr_ok = seen_now;
                    n_phase      = PH_HUNT;
                    n_len        = '0;
                    n_count      = '0;
                    n_sum        = '0;
                    n_seen       = 1'b0;
                end
            end
            default: begin
                emit    = 1'b0;
                n_phase = PH_HUNT;
                n_len   = '0;
                n_count = '0;
                n_sum   = '0;
                n_seen  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_seen  <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_byte    <= i_rx_byte;
            r_index   <= r_count;
            r_last    <= emit_last;
            r_sum_ok  <= emit_sum_ok;
            r_addr_ok <= emit_addr_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_byte  = r_byte;
    assign o_byte_index  = r_index;
    assign o_last_byte   = r_last;
    assign o_checksum_ok = r_sum_ok;
    assign o_address_ok  = r_addr_ok;

`ifndef SYNTHESIS
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_byte_index >= INDEX_W'(3))
        else $error("frame ended before index three");

    a_flags_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_byte |-> !o_checksum_ok && !o_address_ok)
        else $error("check flags set on a non-final beat");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> r_count == '0 && r_sum == '0 && !r_seen)
        else $error("frame state not cleared while hunting");

    a_length_to_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_LENGTH |=> r_phase == PH_BODY && o_out_valid)
        else $error("length beat did not enter frame body");
`endif

endmodule

`default_nettype wire
